FILE: rtl/wfba_pkg.sv
// shared types and constants for the worst-fit block allocator
package wfba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = 5;
	localparam int BIDX_W     = 4;
	localparam int BNUM_W     = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [SIZE_BITS-1:0] size;
		logic [IDX_W-1:0]     idx;
	} scan_t;

	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] size;
		logic                 full;
	} wr_t;

endpackage

FILE: rtl/wfba_cell.sv
// one table entry of the allocator with its stage of the largest-entry scan
module wfba_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [wfba_pkg::IDX_W-1:0]     id,
	input  logic [wfba_pkg::CNT_W-1:0]     count,
	input  wfba_pkg::wr_t                  wr,
	input  wfba_pkg::scan_t                scan_in,
	output wfba_pkg::scan_t                scan_out
);

	logic [wfba_pkg::SIZE_BITS-1:0] size_q;
	logic                           full_q;
	wfba_pkg::scan_t                scan_q;
	wfba_pkg::scan_t                scan_d;
	logic                           elig;
	logic                           take;

	always_comb begin
		elig   = !full_q && (wfba_pkg::CNT_W'(id) < count);
		take   = !scan_in.found || (size_q > scan_in.size);
		scan_d = scan_in;
		if (elig && take) begin
			scan_d.found = 1'b1;
			scan_d.size  = size_q;
			scan_d.idx   = id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			full_q <= 1'b0;
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
			if (wr.en && (wr.idx == id)) begin
				size_q <= wr.size;
				full_q <= wr.full;
			end
		end
	end

	assign scan_out = scan_q;

endmodule

FILE: rtl/worst_fit_block_allocator.sv
// top level of the worst-fit block allocator: control, cell chain and result register
//
// channel   dir  signals                         content
// s_        in   tvalid tready tdata tuser       tuser operation, tdata index and size
// m_        out  tvalid tready tdata tuser       tuser granted, tdata number and remaining size
// cfg_      in   wr_en wr_data                   block_count
//
// a load goes from its input registers straight to the result register, an allocate first
// passes the scan, which walks one cell of the chain per cycle, and the best-entry register
// one item is in work at a time; the next is taken the cycle after its result is registered
// reset clears the table, the full marks and block_count; no clearing pass
// a stalled output holds its result and the following item waits in the done state
module worst_fit_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wfba_pkg::IN_DATA_W-1:0]    s_tdata,  // block_index[3:0], size[19:4]
	input  logic                              s_tuser,  // operation
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wfba_pkg::OUT_DATA_W-1:0]   m_tdata,  // block_number[4:0], remaining_size[20:5]
	output logic                              m_tuser,  // granted
	input  logic                              cfg_wr_en,
	input  logic [wfba_pkg::CNT_W-1:0]        cfg_wr_data
);

	wfba_pkg::state_t                 state_q;
	wfba_pkg::state_t                 state_d;
	logic [wfba_pkg::CNT_W-1:0]       block_count_q;
	logic [wfba_pkg::CNT_W-1:0]       count_sat;
	logic                             op_q;
	logic [wfba_pkg::BIDX_W-1:0]      idx_q;
	logic [wfba_pkg::SIZE_BITS-1:0]   req_q;
	logic                             best_found_q;
	logic [wfba_pkg::SIZE_BITS-1:0]   best_size_q;
	logic [wfba_pkg::IDX_W-1:0]       best_idx_q;
	logic                             out_valid_q;
	logic                             out_granted_q;
	logic [wfba_pkg::BNUM_W-1:0]      out_bnum_q;
	logic [wfba_pkg::SIZE_BITS-1:0]   out_rem_q;
	logic                             accept;
	logic                             start;
	logic                             fire;
	logic                             grant;
	logic [wfba_pkg::SIZE_BITS-1:0]   new_size;
	logic                             res_granted;
	logic [wfba_pkg::BNUM_W-1:0]      res_bnum;
	logic [wfba_pkg::SIZE_BITS-1:0]   res_rem;
	wfba_pkg::wr_t                    wr;
	wfba_pkg::scan_t                  chain [wfba_pkg::MAX_BLOCKS+1];

	assign count_sat = (block_count_q > wfba_pkg::CNT_W'(wfba_pkg::MAX_BLOCKS))
		? wfba_pkg::CNT_W'(wfba_pkg::MAX_BLOCKS) : block_count_q;

	assign accept = s_tvalid && s_tready;
	assign start  = accept && (s_tuser == wfba_pkg::OP_ALLOC);

	assign chain[0] = {start, 1'b0, wfba_pkg::SIZE_BITS'(0), wfba_pkg::IDX_W'(0)};

	for (genvar g = 0; g < wfba_pkg::MAX_BLOCKS; g++) begin : g_cell
		wfba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.id       (wfba_pkg::IDX_W'(g)),
			.count    (count_sat),
			.wr       (wr),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1])
		);
	end

	// next state, handshake and write-back
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		fire     = 1'b0;
		grant    = best_found_q && (best_size_q >= req_q);
		new_size = best_size_q - req_q;
		wr       = '0;
		if (op_q == wfba_pkg::OP_LOAD) begin
			res_granted = 1'b0;
			res_bnum    = '0;
			res_rem     = req_q;
		end else begin
			res_granted = grant;
			res_bnum    = grant ? (wfba_pkg::BNUM_W'(best_idx_q) + wfba_pkg::BNUM_W'(1)) : '0;
			res_rem     = grant ? new_size : '0;
		end
		case (state_q)
			wfba_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == wfba_pkg::OP_ALLOC) ? wfba_pkg::ST_SCAN
						: wfba_pkg::ST_DONE;
				end
			end
			wfba_pkg::ST_SCAN: begin
				if (chain[wfba_pkg::MAX_BLOCKS].valid) begin
					state_d = wfba_pkg::ST_DONE;
				end
			end
			wfba_pkg::ST_DONE: begin
				fire = !out_valid_q || m_tready;
				if (fire) begin
					state_d = wfba_pkg::ST_IDLE;
					if (op_q == wfba_pkg::OP_LOAD) begin
						wr.en   = (32'(idx_q) < wfba_pkg::MAX_BLOCKS);
						wr.idx  = wfba_pkg::IDX_W'(idx_q);
						wr.size = req_q;
						wr.full = 1'b0;
					end else begin
						wr.en   = grant;
						wr.idx  = best_idx_q;
						wr.size = new_size;
						wr.full = (new_size == '0);
					end
				end
			end
			default: begin
				state_d = wfba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wfba_pkg::ST_IDLE;
			block_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				block_count_q <= cfg_wr_data;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			idx_q <= s_tdata[wfba_pkg::BIDX_W-1:0];
			req_q <= s_tdata[wfba_pkg::BIDX_W +: wfba_pkg::SIZE_BITS];
		end
		if (chain[wfba_pkg::MAX_BLOCKS].valid) begin
			best_found_q <= chain[wfba_pkg::MAX_BLOCKS].found;
			best_size_q  <= chain[wfba_pkg::MAX_BLOCKS].size;
			best_idx_q   <= chain[wfba_pkg::MAX_BLOCKS].idx;
		end
		if (fire) begin
			out_granted_q <= res_granted;
			out_bnum_q    <= res_bnum;
			out_rem_q     <= res_rem;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_granted_q;
	assign m_tdata  = wfba_pkg::OUT_DATA_W'({out_rem_q, out_bnum_q});

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the worst-fit block allocator
`timescale 1ns / 100ps

module testbench;

	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 24;
	localparam int WATCH_LIMIT  = 2000;
	localparam int SEG_ITEMS    = 110;

	typedef struct packed {
		logic                           granted;
		logic [wfba_pkg::BNUM_W-1:0]    number;
		logic [wfba_pkg::SIZE_BITS-1:0] remaining;
	} grant_t;

	class alloc_scoreboard;
		logic [wfba_pkg::SIZE_BITS-1:0] free_size [wfba_pkg::MAX_BLOCKS];
		bit                             full_mark [wfba_pkg::MAX_BLOCKS];
		int unsigned                    block_count;
		grant_t                         pending_grants [$];
		int                             mismatch_count;
		int                             result_count;
		int                             grant_count;

		function new();
			for (int i = 0; i < wfba_pkg::MAX_BLOCKS; i++) begin
				free_size[i] = '0;
				full_mark[i] = 1'b0;
			end
			block_count    = 0;
			mismatch_count = 0;
			result_count   = 0;
			grant_count    = 0;
		endfunction

		function void set_count(logic [wfba_pkg::CNT_W-1:0] value);
			block_count = value;
		endfunction

		// accepted input transaction: update the table and queue the expected result
		function void note_request(logic op, logic [wfba_pkg::BIDX_W-1:0] idx,
				logic [wfba_pkg::SIZE_BITS-1:0] sz);
			grant_t      want;
			int unsigned span;
			int          best;
			bit          found;
			want  = '0;
			best  = 0;
			found = 1'b0;
			if (op == wfba_pkg::OP_LOAD) begin
				free_size[idx] = sz;
				full_mark[idx] = 1'b0;
				want.remaining = sz;
			end else begin
				span = (block_count > wfba_pkg::MAX_BLOCKS) ? wfba_pkg::MAX_BLOCKS
					: block_count;
				for (int i = 0; i < span; i++) begin
					if (!full_mark[i] && (!found || free_size[i] > free_size[best])) begin
						best  = i;
						found = 1'b1;
					end
				end
				if (found && free_size[best] >= sz) begin
					free_size[best] = free_size[best] - sz;
					if (free_size[best] == 0)
						full_mark[best] = 1'b1;
					want.granted   = 1'b1;
					want.number    = wfba_pkg::BNUM_W'(best + 1);
					want.remaining = free_size[best];
				end
			end
			pending_grants.push_back(want);
		endfunction

		// output transaction against the oldest expected result
		function void check_result(grant_t got);
			grant_t want;
			result_count++;
			if (got.granted === 1'b1)
				grant_count++;
			if (pending_grants.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: granted %0d number %0d remaining %h",
						got.granted, got.number, got.remaining);
				return;
			end
			want = pending_grants.pop_front();
			if (got.granted !== want.granted || got.number !== want.number ||
					got.remaining !== want.remaining) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"result %0d: expected granted %0d number %0d remaining %h,",
						" got granted %0d number %0d remaining %h"},
						result_count, want.granted, want.number, want.remaining,
						got.granted, got.number, got.remaining);
			end
		endfunction

		function void flag_leftover();
			if (pending_grants.size() != 0) begin
				$display("%0d expected results never arrived", pending_grants.size());
				mismatch_count += pending_grants.size();
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [wfba_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [wfba_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tuser;
	logic                            cfg_wr_en;
	logic [wfba_pkg::CNT_W-1:0]      cfg_wr_data;

	alloc_scoreboard sb;
	int              send_idle_pct;
	int              recv_stall_pct;
	bit              recv_hold_go;
	int              idle_cycles;
	int              items_sent;
	int              settings_used;

	worst_fit_block_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_hold_go) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				recv_hold_go = 1'b0;
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// sampled between edges, where every signal is settled for the coming edge
	always @(negedge clk) begin
		grant_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.granted   = m_tuser;
				got.number    = m_tdata[wfba_pkg::BNUM_W-1:0];
				got.remaining = m_tdata[wfba_pkg::BNUM_W +: wfba_pkg::SIZE_BITS];
				sb.check_result(got);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		wait (idle_cycles >= WATCH_LIMIT);
		$display("no transaction for %0d cycles", WATCH_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic send_item(input logic op, input logic [wfba_pkg::BIDX_W-1:0] idx,
			input logic [wfba_pkg::SIZE_BITS-1:0] sz);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= wfba_pkg::IN_DATA_W'({sz, idx});
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		sb.note_request(op, idx, sz);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input logic [wfba_pkg::CNT_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_count(value);
		settings_used++;
	endtask

	function automatic logic [wfba_pkg::SIZE_BITS-1:0] pick_size();
		case ($urandom_range(0, 5))
			0:       return '0;
			1, 2:    return wfba_pkg::SIZE_BITS'($urandom_range(1, 15));
			3:       return wfba_pkg::SIZE_BITS'($urandom_range(16, 1023));
			4:       return wfba_pkg::SIZE_BITS'($urandom);
			default: return '1;
		endcase
	endfunction

	// preload the entries in use, then a mix of allocates and reloads
	task automatic run_segment(input int n, input int count, input int hold_at);
		int                          eff;
		int                          r;
		logic [wfba_pkg::BIDX_W-1:0] idx;
		eff = (count > wfba_pkg::MAX_BLOCKS) ? wfba_pkg::MAX_BLOCKS : count;
		drain();
		write_count(wfba_pkg::CNT_W'(count));
		for (int k = 0; k < eff; k++)
			send_item(wfba_pkg::OP_LOAD, wfba_pkg::BIDX_W'(k), pick_size());
		for (int k = 0; k < n; k++) begin
			if (k == hold_at)
				recv_hold_go = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 58) begin
				send_item(wfba_pkg::OP_ALLOC, wfba_pkg::BIDX_W'($urandom), pick_size());
			end else begin
				if (eff > 0 && r < 92)
					idx = wfba_pkg::BIDX_W'($urandom_range(0, eff - 1));
				else
					idx = wfba_pkg::BIDX_W'($urandom);
				send_item(wfba_pkg::OP_LOAD, idx, pick_size());
			end
		end
	endtask

	initial begin
		int idle_tab [4];
		int stall_tab [4];
		int count;
		idle_tab      = '{0, 52, 0, 23};
		stall_tab     = '{0, 0, 52, 23};
		sb            = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold_go  = 1'b0;
		idle_cycles   = 0;
		items_sent    = 0;
		settings_used = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no entry in use after reset
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h0000);
		drain();
		write_count(wfba_pkg::CNT_W'(wfba_pkg::MAX_BLOCKS));
		// zero requests on empty entries
		send_item(wfba_pkg::OP_ALLOC, 4'hF, 16'h0000);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h0000);
		send_item(wfba_pkg::OP_LOAD, 4'hF, 16'hFFFF);
		send_item(wfba_pkg::OP_LOAD, 4'h0, 16'h5555);
		send_item(wfba_pkg::OP_LOAD, 4'hA, 16'hFFFF);
		// tie between two largest entries, then the other one
		send_item(wfba_pkg::OP_ALLOC, 4'h5, 16'hFFFF);
		send_item(wfba_pkg::OP_ALLOC, 4'hA, 16'hFFFF);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h0001);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'hFFFF);
		send_item(wfba_pkg::OP_LOAD, 4'h5, 16'hAAAA);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'hAAAA);
		drain();
		write_count(5'd1);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h5554);
		// all entries in use are full
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h0000);
		send_item(wfba_pkg::OP_LOAD, 4'h0, 16'h0003);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h0004);
		drain();
		// count beyond the table saturates
		write_count(5'd31);
		send_item(wfba_pkg::OP_ALLOC, 4'h0, 16'h0000);
		send_item(wfba_pkg::OP_LOAD, 4'hF, 16'h1234);
		send_item(wfba_pkg::OP_ALLOC, 4'h3, 16'h1234);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			send_idle_pct  = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			for (int seg = 0; seg < 4; seg++) begin
				case (seg)
					0:       count = wfba_pkg::MAX_BLOCKS;
					1:       count = $urandom_range(2, wfba_pkg::MAX_BLOCKS - 1);
					2:       count = (ph % 2) ? 0 : 1;
					default: count = (ph < 2) ? 31
						: $urandom_range(wfba_pkg::MAX_BLOCKS + 1, 30);
				endcase
				run_segment(SEG_ITEMS, count, (ph == 0 && seg == 0) ? 40 : -1);
			end
		end

		drain();
		sb.flag_leftover();
		$display("covered %0d input items under %0d block count settings",
			items_sent, settings_used);
		$display("four idling phases, checked %0d results, %0d of them grants",
			sb.result_count, sb.grant_count);
		if (sb.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/wfba_pkg.sv
rtl/wfba_cell.sv
rtl/worst_fit_block_allocator.sv
verif/testbench.sv
